>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the BMP to RGB565 stream decoder.
// No dependencies; include guarded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/bmp24_rgb_pkg.sv
// Shared types and constants of the BMP to RGB565 stream decoder.
// No dependencies.
`timescale 1ns / 1ps

package bmp24_rgb_pkg;

    localparam int CFG_W = 13;

    // configuration register indexes
    localparam logic REG_DISP_W = 1'b0;
    localparam logic REG_DISP_H = 1'b1;

    localparam logic [CFG_W-1:0] DISP_W_RESET = 13'd128;
    localparam logic [CFG_W-1:0] DISP_H_RESET = 13'd160;

    // parser phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXEL  = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_WINDOW = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_SIGNATURE = 2'd0;
    localparam logic [1:0] ERR_PLANES    = 2'd1;
    localparam logic [1:0] ERR_FORMAT    = 2'd2;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd3;

    // header byte positions at which a field is complete
    localparam logic [5:0] POS_SIGNATURE   = 6'd1;
    localparam logic [5:0] POS_WIDTH       = 6'd21;
    localparam logic [5:0] POS_HEIGHT      = 6'd25;
    localparam logic [5:0] POS_PLANES      = 6'd27;
    localparam logic [5:0] POS_DEPTH       = 6'd29;
    localparam logic [5:0] POS_COMPRESSION = 6'd33;
    localparam logic [5:0] POS_PIXELS      = 6'd53;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BMP_PLANES    = 16'd1;
    localparam logic [15:0] BMP_DEPTH     = 16'd24;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel;
        logic [15:0] win_w;
        logic [15:0] win_h;
        logic [15:0] col;
        logic [15:0] row;
        logic [1:0]  err;
        logic        last;
    } res_t;

    function automatic logic [15:0] to_rgb565(input logic [7:0] blue,
                                             input logic [7:0] green,
                                             input logic [7:0] red);
        return {red[7:3], green[7:2], blue[7:3]};
    endfunction

endpackage

>>> src/bmp24_rgb_out.sv
// Result register of the BMP to RGB565 decoder: holds one result word
// until the master side takes it. Depends on bmp24_rgb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp24_rgb_out
    import bmp24_rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_t        res,
    output logic        can_load,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // pixel_rgb565, window_width, window_height,
                                   // pixel_column, pixel_row, error_code, zero fill
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast    // last_pixel
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.err, res_reg.row, res_reg.col,
                       res_reg.win_h, res_reg.win_w, res_reg.pixel};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

    `ASSERT_SAME(a_no_overwrite, clk, rst_n, load, can_load)
    `ASSERT_NEXT(a_load_shows, clk, rst_n, load, valid_reg)
    `ASSERT_SAME(a_last_only_pixel, clk, rst_n, valid_reg && res_reg.last,
                 res_reg.kind == KIND_PIXEL)

endmodule

>>> src/bmp24_stream_to_rgb565_top.sv
// Top level of the BMP to RGB565 stream decoder: header parser, pixel
// packer and crop counters. Depends on bmp24_rgb_pkg, bmp24_rgb_out and assert_macros.svh.
//
//  channel   direction  signals                          word
//  s_*       in         tvalid tready tdata[7:0] tuser   one file byte
//  m_*       out        tvalid tready tdata tuser tlast  one result
//  cfg_*     in         we addr wdata                    display size
//
// One byte per cycle while s_tready is high: the parser state loads at the edge that
// accepts the byte, and the output register loads at that edge if the byte yields a result.
// s_tready is low only while a result waits and m_tready is low.
// Reset clears the parser to the header phase and the display to 128 x 160.
// Results appear in the cycle after the byte that causes them is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp24_stream_to_rgb565_top
    import bmp24_rgb_pkg::*;
#(
    parameter int DIM_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // data_byte
    input  logic             s_tuser,   // start_of_file
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [87:0]      m_tdata,   // pixel_rgb565, window_width, window_height,
                                        // pixel_column, pixel_row, error_code, zero fill
    output logic [1:0]       m_tuser,   // result_kind
    output logic             m_tlast,   // last_pixel
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int MW = (DIM_BITS > CFG_W) ? DIM_BITS : CFG_W;
    localparam int SKW = DIM_BITS + 2;

    logic [CFG_W-1:0]    disp_w_reg, disp_h_reg;
    logic [1:0]          phase_reg, phase_next;
    logic [5:0]          hcnt_reg, hcnt_next;
    logic [31:0]         shift_reg, shift_next;
    logic [DIM_BITS-1:0] img_w_reg, img_w_next, img_h_reg, img_h_next;
    logic                w_big_reg, w_big_next, h_big_reg, h_big_next;
    logic [DIM_BITS-1:0] shown_w_reg, shown_w_next, shown_h_reg, shown_h_next;
    logic [1:0]          bip_reg, bip_next;
    logic [7:0]          blue_reg, blue_next, green_reg, green_next;
    logic [DIM_BITS-1:0] col_reg, col_next, row_reg, row_next;
    logic [SKW-1:0]      skip_reg, skip_next;

    // parser view after an optional restart
    logic [1:0]          cur_phase;
    logic [5:0]          cur_hcnt;
    logic [31:0]         cur_shift;
    logic [DIM_BITS-1:0] cur_img_w, cur_img_h, cur_shown_w, cur_shown_h, cur_col, cur_row;
    logic                cur_w_big, cur_h_big;
    logic [1:0]          cur_bip;
    logic [SKW-1:0]      cur_skip;

    logic [31:0]         field;
    logic [31:0]         h_abs;
    logic [MW-1:0]       min_w, min_h;
    logic                row_end, last;
    logic [SKW-1:0]      crop_bytes, skip_len, skip_dec;

    logic accept, emit, can_load;
    res_t res;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_w_reg <= DISP_W_RESET;
            disp_h_reg <= DISP_H_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_DISP_W)
            begin
                disp_w_reg <= cfg_wdata;
            end
            else
            begin
                disp_h_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        if (s_tuser)
        begin
            cur_phase   = PH_HEADER;
            cur_hcnt    = '0;
            cur_shift   = '0;
            cur_img_w   = '0;
            cur_img_h   = '0;
            cur_w_big   = 1'b0;
            cur_h_big   = 1'b0;
            cur_shown_w = '0;
            cur_shown_h = '0;
            cur_bip     = '0;
            cur_col     = '0;
            cur_row     = '0;
            cur_skip    = '0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_hcnt    = hcnt_reg;
            cur_shift   = shift_reg;
            cur_img_w   = img_w_reg;
            cur_img_h   = img_h_reg;
            cur_w_big   = w_big_reg;
            cur_h_big   = h_big_reg;
            cur_shown_w = shown_w_reg;
            cur_shown_h = shown_h_reg;
            cur_bip     = bip_reg;
            cur_col     = col_reg;
            cur_row     = row_reg;
            cur_skip    = skip_reg;
        end
    end

    assign field = {s_tdata, cur_shift[31:8]};
    assign h_abs = field[31] ? (32'd0 - field) : field;
    assign min_w = (MW'(cur_img_w) < MW'(disp_w_reg)) ? MW'(cur_img_w) : MW'(disp_w_reg);
    assign min_h = (MW'(cur_img_h) < MW'(disp_h_reg)) ? MW'(cur_img_h) : MW'(disp_h_reg);

    assign row_end = ((DIM_BITS+1)'(cur_col) + 1'b1) >= (DIM_BITS+1)'(cur_shown_w);
    assign last    = row_end && (((DIM_BITS+1)'(cur_row) + 1'b1)
                                 >= (DIM_BITS+1)'(cur_shown_h));

    // cropped columns times three, plus the padding, which is width mod 4
    assign crop_bytes = SKW'(cur_img_w - cur_shown_w);
    assign skip_len   = (crop_bytes << 1) + crop_bytes + SKW'(cur_img_w[1:0]);
    assign skip_dec   = cur_skip - 1'b1;

    always_comb
    begin
        phase_next   = cur_phase;
        hcnt_next    = cur_hcnt;
        shift_next   = cur_shift;
        img_w_next   = cur_img_w;
        img_h_next   = cur_img_h;
        w_big_next   = cur_w_big;
        h_big_next   = cur_h_big;
        shown_w_next = cur_shown_w;
        shown_h_next = cur_shown_h;
        bip_next     = cur_bip;
        blue_next    = blue_reg;
        green_next   = green_reg;
        col_next     = cur_col;
        row_next     = cur_row;
        skip_next    = cur_skip;
        emit         = 1'b0;
        res          = '0;

        case (cur_phase)
            PH_HEADER:
            begin
                shift_next = field;
                hcnt_next  = cur_hcnt + 1'b1;
                case (cur_hcnt)
                    POS_SIGNATURE:
                    begin
                        if (field[31:16] != BMP_SIGNATURE)
                        begin
                            emit       = 1'b1;
                            res.kind   = KIND_ERROR;
                            res.err    = ERR_SIGNATURE;
                            phase_next = PH_DONE;
                        end
                    end
                    POS_WIDTH:
                    begin
                        img_w_next = field[DIM_BITS-1:0];
                        w_big_next = |field[31:DIM_BITS];
                    end
                    POS_HEIGHT:
                    begin
                        img_h_next = h_abs[DIM_BITS-1:0];
                        h_big_next = |h_abs[31:DIM_BITS];
                    end
                    POS_PLANES:
                    begin
                        if (field[31:16] != BMP_PLANES)
                        begin
                            emit       = 1'b1;
                            res.kind   = KIND_ERROR;
                            res.err    = ERR_PLANES;
                            phase_next = PH_DONE;
                        end
                    end
                    POS_DEPTH:
                    begin
                        if (field[31:16] != BMP_DEPTH)
                        begin
                            emit       = 1'b1;
                            res.kind   = KIND_ERROR;
                            res.err    = ERR_FORMAT;
                            phase_next = PH_DONE;
                        end
                    end
                    POS_COMPRESSION:
                    begin
                        emit = 1'b1;
                        if (field != 32'd0)
                        begin
                            res.kind   = KIND_ERROR;
                            res.err    = ERR_FORMAT;
                            phase_next = PH_DONE;
                        end
                        else if (cur_w_big || cur_h_big)
                        begin
                            res.kind   = KIND_ERROR;
                            res.err    = ERR_TOO_LARGE;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            shown_w_next = min_w[DIM_BITS-1:0];
                            shown_h_next = min_h[DIM_BITS-1:0];
                            res.kind     = KIND_WINDOW;
                            res.win_w    = 16'(min_w[DIM_BITS-1:0]);
                            res.win_h    = 16'(min_h[DIM_BITS-1:0]);
                            if (min_w == '0 || min_h == '0)
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        if (cur_hcnt >= POS_PIXELS)
                        begin
                            phase_next = PH_PIXEL;
                        end
                    end
                endcase
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_PIXEL;
                end
            end
            PH_PIXEL:
            begin
                case (cur_bip)
                    2'd0:
                    begin
                        blue_next = s_tdata;
                        bip_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        green_next = s_tdata;
                        bip_next   = 2'd2;
                    end
                    default:
                    begin
                        emit      = 1'b1;
                        bip_next  = 2'd0;
                        res.kind  = KIND_PIXEL;
                        res.pixel = to_rgb565(blue_reg, green_reg, s_tdata);
                        res.col   = 16'(cur_col);
                        res.row   = 16'(cur_row);
                        res.last  = last;
                        if (!row_end)
                        begin
                            col_next = cur_col + 1'b1;
                        end
                        else
                        begin
                            col_next = '0;
                            row_next = cur_row + 1'b1;
                            if (last)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                skip_next = skip_len;
                                if (skip_len != '0)
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                // done: drop bytes until the next start mark
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hcnt_reg    <= '0;
            shift_reg   <= '0;
            img_w_reg   <= '0;
            img_h_reg   <= '0;
            w_big_reg   <= 1'b0;
            h_big_reg   <= 1'b0;
            shown_w_reg <= '0;
            shown_h_reg <= '0;
            bip_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            skip_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            hcnt_reg    <= hcnt_next;
            shift_reg   <= shift_next;
            img_w_reg   <= img_w_next;
            img_h_reg   <= img_h_next;
            w_big_reg   <= w_big_next;
            h_big_reg   <= h_big_next;
            shown_w_reg <= shown_w_next;
            shown_h_reg <= shown_h_next;
            bip_reg     <= bip_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            skip_reg    <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
        end
    end

    bmp24_rgb_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && emit),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `ASSERT_SAME(a_skip_nonzero, clk, rst_n, phase_reg == PH_SKIP, skip_reg != '0)
    `ASSERT_SAME(a_pixel_window, clk, rst_n, phase_reg == PH_PIXEL,
                 shown_w_reg != '0 && shown_h_reg != '0)
    `ASSERT_SAME(a_col_in_window, clk, rst_n, phase_reg == PH_PIXEL, col_reg < shown_w_reg)
    `ASSERT_SAME(a_bip_range, clk, rst_n, 1'b1, bip_reg != 2'd3)
    `ASSERT_NEXT(a_pixel_out, clk, rst_n,
                 accept && !s_tuser && phase_reg == PH_PIXEL && bip_reg == 2'd2,
                 m_tvalid && m_tuser == KIND_PIXEL)

endmodule

>>> tb/testbench.sv
// Self-checking bench for bmp24_stream_to_rgb565_top: streams BMP files byte by byte
// and checks each result word against a cycle-free model of the parser.
// Depends on bmp24_rgb_pkg and the RTL of the decoder.
`timescale 1ns / 1ps

module testbench;
    import bmp24_rgb_pkg::*;

    localparam int DIM_BITS = 16;
    localparam logic [32:0] DIM_LIMIT = 33'd1 << DIM_BITS;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_PHASES = 8;
    localparam int PHASE_BYTES = 56;

    typedef enum int
    {
        FILE_GOOD,
        FILE_BAD_SIGNATURE,
        FILE_BAD_PLANES,
        FILE_BAD_DEPTH,
        FILE_BAD_COMPRESSION,
        FILE_TOO_LARGE,
        FILE_BOUNDARY,
        FILE_EMPTY,
        FILE_BROKEN,
        FILE_KINDS
    } file_flaw_t;

    // Expected decoder results, worked out byte by byte from the file stream.
    class rgb565_scoreboard;
        logic [12:0] disp_w;
        logic [12:0] disp_h;
        logic [1:0]  parse_ph;
        logic [5:0]  hdr_pos;
        logic [31:0] shift;
        logic [31:0] img_w;
        logic [31:0] img_h;
        logic [15:0] win_w;
        logic [15:0] win_h;
        logic [1:0]  bip;
        logic [15:0] held;
        logic [15:0] col;
        logic [15:0] row;
        logic [17:0] skip;
        res_t        pending_results[$];
        int          fails;

        function new();
            disp_w = DISP_W_RESET;
            disp_h = DISP_H_RESET;
            fails = 0;
            restart();
        endfunction

        function void restart();
            parse_ph = PH_HEADER;
            hdr_pos = '0;
            shift = '0;
            img_w = '0;
            img_h = '0;
            win_w = '0;
            win_h = '0;
            bip = '0;
            held = '0;
            col = '0;
            row = '0;
            skip = '0;
        endfunction

        function void write_reg(logic idx, logic [12:0] value);
            if (idx == REG_DISP_W)
                disp_w = value;
            else
                disp_h = value;
        endfunction

        function void push_error(logic [1:0] code);
            res_t r;
            r = '0;
            r.kind = KIND_ERROR;
            r.err = code;
            pending_results.push_back(r);
            parse_ph = PH_DONE;
        endfunction

        function void note_byte(logic [7:0] b, logic sof);
            res_t        r;
            logic [5:0]  pos;
            logic [31:0] row_bytes;
            logic [31:0] gap;
            logic [1:0]  pad;
            bit          row_end;
            bit          at_last;
            r = '0;
            if (sof)
                restart();
            case (parse_ph)
                PH_HEADER:
                begin
                    pos = hdr_pos;
                    shift = {b, shift[31:8]};
                    hdr_pos = pos + 6'd1;
                    if (pos == POS_SIGNATURE)
                    begin
                        if (shift[31:16] != BMP_SIGNATURE)
                            push_error(ERR_SIGNATURE);
                    end
                    else if (pos == POS_WIDTH)
                        img_w = shift;
                    else if (pos == POS_HEIGHT)
                        img_h = shift[31] ? -shift : shift;
                    else if (pos == POS_PLANES)
                    begin
                        if (shift[31:16] != BMP_PLANES)
                            push_error(ERR_PLANES);
                    end
                    else if (pos == POS_DEPTH)
                    begin
                        if (shift[31:16] != BMP_DEPTH)
                            push_error(ERR_FORMAT);
                    end
                    else if (pos == POS_COMPRESSION)
                    begin
                        if (shift != 32'd0)
                            push_error(ERR_FORMAT);
                        else if ({1'b0, img_w} >= DIM_LIMIT || {1'b0, img_h} >= DIM_LIMIT)
                            push_error(ERR_TOO_LARGE);
                        else
                        begin
                            win_w = (img_w < {19'd0, disp_w}) ? img_w[15:0] : {3'd0, disp_w};
                            win_h = (img_h < {19'd0, disp_h}) ? img_h[15:0] : {3'd0, disp_h};
                            r.kind = KIND_WINDOW;
                            r.win_w = win_w;
                            r.win_h = win_h;
                            pending_results.push_back(r);
                            if (win_w == 16'd0 || win_h == 16'd0)
                                parse_ph = PH_DONE;
                        end
                    end
                    else if (pos >= POS_PIXELS)
                        parse_ph = PH_PIXEL;
                end
                PH_SKIP:
                begin
                    skip = skip - 18'd1;
                    if (skip == 18'd0)
                        parse_ph = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    if (bip == 2'd0)
                    begin
                        held = {8'h00, b};
                        bip = 2'd1;
                    end
                    else if (bip == 2'd1)
                    begin
                        held[15:8] = b;
                        bip = 2'd2;
                    end
                    else
                    begin
                        row_end = ({1'b0, col} + 17'd1) >= {1'b0, win_w};
                        at_last = row_end && (({1'b0, row} + 17'd1) >= {1'b0, win_h});
                        r.kind = KIND_PIXEL;
                        // red from this byte, green and blue from the held pair
                        r.pixel = {b[7:3], held[15:10], held[7:3]};
                        r.col = col;
                        r.row = row;
                        r.last = at_last;
                        pending_results.push_back(r);
                        bip = 2'd0;
                        if (!row_end)
                            col = col + 16'd1;
                        else
                        begin
                            col = '0;
                            row = row + 16'd1;
                            if (at_last)
                                parse_ph = PH_DONE;
                            else
                            begin
                                // skip cropped columns and pad each row to a multiple of 4 bytes
                                row_bytes = img_w * 32'd3;
                                pad = 2'd0 - row_bytes[1:0];
                                gap = (img_w - {16'd0, win_w}) * 32'd3 + {30'd0, pad};
                                skip = gap[17:0];
                                if (skip != 18'd0)
                                    parse_ph = PH_SKIP;
                            end
                        end
                    end
                end
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            fails++;
        endtask

        task compare_field(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", field, got, want));
        endtask

        task check_result(logic [1:0] kind, logic [87:0] data, logic got_last);
            res_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected word kind %0d data %h", kind, data));
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", 16'(kind), 16'(want.kind));
            compare_field("pixel", data[15:0], want.pixel);
            compare_field("window_width", data[31:16], want.win_w);
            compare_field("window_height", data[47:32], want.win_h);
            compare_field("column", data[63:48], want.col);
            compare_field("row", data[79:64], want.row);
            compare_field("error_code", 16'(data[81:80]), 16'(want.err));
            compare_field("fill", 16'(data[87:82]), 16'd0);
            compare_field("last", 16'(got_last), 16'(want.last));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [87:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;
    logic             cfg_we;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    rgb565_scoreboard sb = new();

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int          hold_left;
    int          stuck_cycles;
    logic [12:0] cur_h;
    logic [7:0]  file_bytes[$];
    int          phase_w[N_PHASES] = '{128, 5, 1, 0, 4096, 3, 8191, 6};
    int          phase_h[N_PHASES] = '{160, 3, 1, 4, 4096, 0, 8191, 2};

    bmp24_stream_to_rgb565_top #(.DIM_BITS(DIM_BITS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tuser);
            if (cfg_we)
                sb.write_reg(cfg_addr, cfg_wdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial
    begin
        m_tready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task send_byte(input logic [7:0] b, input logic sof);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= sof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task set_display(input logic [12:0] w, input logic [12:0] h);
        cfg_we <= 1'b1;
        cfg_addr <= REG_DISP_W;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_addr <= REG_DISP_H;
        cfg_wdata <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_h = h;
    endtask

    function void push_le(logic [31:0] value, int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(value[8*i +: 8]);
    endfunction

    function logic [7:0] pixel_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task make_file(input file_flaw_t flaw);
        logic [31:0] w;
        logic [31:0] h_abs;
        logic [31:0] h_field;
        logic [31:0] planes;
        logic [31:0] depth;
        logic [31:0] comp;
        int          rows;
        int          row_len;
        int          cut;
        file_bytes.delete();
        w = $urandom_range(1, 9);
        h_abs = $urandom_range(1, 5);
        h_field = $urandom_range(0, 1) ? -h_abs : h_abs;
        planes = 32'd1;
        depth = 32'd24;
        comp = 32'd0;
        case (flaw)
            FILE_BAD_PLANES:
                planes = $urandom_range(0, 1) ? 32'd0 : $urandom_range(2, 65535);
            FILE_BAD_DEPTH:
            begin
                depth = $urandom_range(0, 65535);
                if (depth == 32'd24)
                    depth = 32'd32;
            end
            FILE_BAD_COMPRESSION:
            begin
                comp = $urandom_range(0, 1) ? 32'd1 : $urandom;
                if (comp == 32'd0)
                    comp = 32'h8000_0000;
            end
            FILE_TOO_LARGE:
                case ($urandom_range(0, 4))
                    0: w = 32'h0001_0000;
                    1: w = $urandom | 32'h8000_0000;
                    2: w = $urandom_range(32'h7FFF_FFFF, 32'h0001_0000);
                    3: h_field = 32'h0001_0000 + $urandom_range(0, 100);
                    default: h_field = $urandom_range(0, 1) ? 32'hFFFF_0000 : 32'h8000_0000;
                endcase
            FILE_BOUNDARY:
                // largest size that still passes; the data is cut short below
                case ($urandom_range(0, 2))
                    0: w = 32'd65535;
                    1: h_field = 32'd65535;
                    default: h_field = -32'd65535;
                endcase
            FILE_EMPTY:
                if ($urandom_range(0, 1))
                    w = 32'd0;
                else
                    h_field = 32'd0;
            default:
                ;
        endcase

        if (flaw == FILE_BAD_SIGNATURE)
        begin
            file_bytes.push_back(8'h42 ^ 8'($urandom_range(0, 1) << $urandom_range(0, 7)));
            file_bytes.push_back(8'h4D ^ (8'd1 << $urandom_range(0, 7)));
        end
        else
            push_le({16'd0, BMP_SIGNATURE}, 2);
        for (int i = 2; i < 18; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        push_le(w, 4);
        push_le(h_field, 4);
        push_le(planes, 2);
        push_le(depth, 2);
        push_le(comp, 4);
        for (int i = 34; i < 54; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));

        if (flaw == FILE_GOOD || flaw == FILE_BROKEN)
        begin
            rows = (h_abs < cur_h) ? h_abs : cur_h;
            row_len = (w * 3 + 3) & ~3;
            for (int i = 0; i < rows * row_len; i++)
                file_bytes.push_back(pixel_byte());
        end
        else if (flaw == FILE_BOUNDARY)
        begin
            for (int i = $urandom_range(0, 30); i > 0; i--)
                file_bytes.push_back(pixel_byte());
        end

        if (flaw == FILE_BROKEN)
        begin
            cut = $urandom_range(0, 2) == 0 ? $urandom_range(1, 6)
                                            : $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
        else
        begin
            // trailing bytes after an error or the last pixel are dropped
            for (int i = $urandom_range(0, 2); i > 0; i--)
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int         sent;
        int         file_no;
        int         pick;
        file_flaw_t flaw;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_DISP_W;
        cfg_wdata = '0;
        hold_req = 1'b0;
        stuck_cycles = 0;
        tx_idle_pct = 23;
        rx_idle_pct = 65;
        cur_h = DISP_H_RESET;
        file_no = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // a valid signature with no start mark, then broken signatures
        send_byte(8'h42, 1'b0);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h4D, 1'b1);
        send_byte(8'h42, 1'b0);
        send_byte(8'h5A, 1'b0);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p < 3)
            begin
                tx_idle_pct = 23;
                rx_idle_pct = 65;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 65;
                rx_idle_pct = 23;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p > 0)
            begin
                wait_drained();
                set_display(13'(phase_w[p]), 13'(phase_h[p]));
            end
            if (p == 6)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                if (file_no < FILE_KINDS)
                    flaw = file_flaw_t'(file_no);
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                        flaw = FILE_GOOD;
                    else if (pick < 60)
                        flaw = FILE_BAD_SIGNATURE;
                    else if (pick < 65)
                        flaw = FILE_BAD_PLANES;
                    else if (pick < 70)
                        flaw = FILE_BAD_DEPTH;
                    else if (pick < 75)
                        flaw = FILE_BAD_COMPRESSION;
                    else if (pick < 82)
                        flaw = FILE_TOO_LARGE;
                    else if (pick < 86)
                        flaw = FILE_BOUNDARY;
                    else if (pick < 91)
                        flaw = FILE_EMPTY;
                    else
                        flaw = FILE_BROKEN;
                end
                make_file(flaw);
                for (int i = 0; i < file_bytes.size(); i++)
                    send_byte(file_bytes[i], i == 0);
                sent += file_bytes.size();
                file_no++;
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.fails == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
